// File: src/sfr_pkg.sv
// constants, register codes and helpers shared by the find-and-replace modules
package sfr_pkg;

  localparam int unsigned MaxPattern     = 8;
  localparam int unsigned MaxReplacement = 8;
  localparam int unsigned QueueDepth     = 2;
  localparam int unsigned ByteW          = 8;
  localparam int unsigned LenW           = 4;
  localparam int unsigned CfgDataW       = 64;
  localparam int unsigned CfgIdxW        = 2;

  typedef enum logic [CfgIdxW-1:0] {
    CfgPatternBytes = 2'd0,
    CfgPatternLen   = 2'd1,
    CfgReplBytes    = 2'd2,
    CfgReplLen      = 2'd3
  } cfg_reg_e;

  // byte pos of a packed register, zero beyond the eighth byte
  function automatic logic [ByteW-1:0] packed_byte(logic [CfgDataW-1:0] word_bits,
                                                   int unsigned pos);
    logic [CfgDataW-1:0] sh;
    sh = word_bits >> (ByteW * pos);
    return sh[ByteW-1:0];
  endfunction

endpackage

// File: src/sfr_queue.sv
// small command queue between the matching front and the emitting back
module sfr_queue #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = sfr_pkg::QueueDepth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             full_o,
  output logic             empty_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// File: src/sfr_front.sv
// front end: byte window, pattern compare and command build
module sfr_front #(
  parameter int unsigned MAX_PATTERN     = sfr_pkg::MaxPattern,
  parameter int unsigned MAX_REPLACEMENT = sfr_pkg::MaxReplacement,
  localparam int unsigned ListLen = (MAX_PATTERN > MAX_REPLACEMENT) ?
                                    MAX_PATTERN : MAX_REPLACEMENT,
  localparam int unsigned CountW  = $clog2(ListLen + 1)
) (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  logic                                        accept_i,
  input  logic [sfr_pkg::ByteW-1:0]                   in_byte_i,
  input  logic                                        in_last_i,
  input  logic [sfr_pkg::CfgDataW-1:0]                pattern_bytes_i,
  input  logic [sfr_pkg::LenW-1:0]                    pattern_length_i,
  input  logic [sfr_pkg::CfgDataW-1:0]                replacement_bytes_i,
  input  logic [sfr_pkg::LenW-1:0]                    replacement_length_i,
  output logic                                        cmd_push_o,
  output logic [ListLen-1:0][sfr_pkg::ByteW-1:0]      cmd_bytes_o,
  output logic [CountW-1:0]                           cmd_count_o,
  output logic                                        cmd_last_o
);

  localparam int unsigned FillW = $clog2(MAX_PATTERN + 1);
  localparam int unsigned IdxW  = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

  logic [MAX_PATTERN-1:0][sfr_pkg::ByteW-1:0] win_q, win_d;
  logic [FillW-1:0]                           fill_q, fill_d;
  logic [ListLen-1:0][sfr_pkg::ByteW-1:0]     w_drop, w_ins, w_shift;
  logic [FillW-1:0]                           plen, drop, base, f_new;
  logic [CountW-1:0]                          rlen;
  logic                                       over, full_win, hit;

  assign plen = (32'(pattern_length_i) > MAX_PATTERN) ? FillW'(MAX_PATTERN) :
                                                         FillW'(pattern_length_i);
  assign rlen = (32'(replacement_length_i) > MAX_REPLACEMENT) ? CountW'(MAX_REPLACEMENT) :
                                                                 CountW'(replacement_length_i);

  // shortened pattern: keep only the newest plen-1 bytes
  assign over     = (plen != '0) && (fill_q >= plen);
  assign drop     = over ? fill_q - (plen - 1'b1) : '0;
  assign base     = over ? plen - 1'b1 : fill_q;
  assign f_new    = base + 1'b1;
  assign full_win = (plen != '0) && (f_new == plen);

  always_comb begin
    int unsigned src;
    for (int j = 0; j < ListLen; j++) begin
      src = j + int'(drop);
      if (src < MAX_PATTERN) begin
        w_drop[j] = win_q[src[IdxW-1:0]];
      end else begin
        w_drop[j] = '0;
      end
    end
  end

  always_comb begin
    for (int j = 0; j < ListLen; j++) begin
      w_ins[j] = (32'(j) == 32'(base)) ? in_byte_i : w_drop[j];
    end
  end

  assign w_shift = w_ins >> sfr_pkg::ByteW;

  always_comb begin
    hit = full_win;
    for (int i = 0; i < MAX_PATTERN; i++) begin
      if ((FillW'(i) < plen) &&
          (w_ins[i] != sfr_pkg::packed_byte(pattern_bytes_i, i))) begin
        hit = 1'b0;
      end
    end
  end

  always_comb begin
    cmd_bytes_o = w_ins;
    cmd_last_o  = in_last_i;
    if (hit) begin
      for (int j = 0; j < ListLen; j++) begin
        cmd_bytes_o[j] = sfr_pkg::packed_byte(replacement_bytes_i, j);
      end
      cmd_count_o = rlen;
    end else if (in_last_i || (plen == '0)) begin
      cmd_count_o = CountW'(f_new);
    end else if (full_win) begin
      cmd_count_o = CountW'(1);
    end else begin
      cmd_count_o = '0;
    end
  end

  assign cmd_push_o = accept_i && ((cmd_count_o != '0) || in_last_i);

  always_comb begin
    win_d  = w_ins[MAX_PATTERN-1:0];
    fill_d = f_new;
    if (in_last_i || (plen == '0) || hit) begin
      fill_d = '0;
    end else if (full_win) begin
      win_d  = w_shift[MAX_PATTERN-1:0];
      fill_d = base;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else if (accept_i) begin
      fill_q <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      win_q <= win_d;
    end
  end

endmodule

// File: src/sfr_back.sv
// back end: expands queued commands into output beats
module sfr_back #(
  parameter int unsigned LIST_LEN = sfr_pkg::MaxPattern,
  localparam int unsigned CountW  = $clog2(LIST_LEN + 1)
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   q_empty_i,
  input  logic [LIST_LEN-1:0][sfr_pkg::ByteW-1:0] q_bytes_i,
  input  logic [CountW-1:0]                      q_count_i,
  input  logic                                   q_last_i,
  output logic                                   q_pop_o,
  input  logic                                   pop,
  output logic                                   empty,
  output logic [sfr_pkg::ByteW-1:0]              out_byte_o,
  output logic                                   out_byte_valid_o,
  output logic                                   out_last_o
);

  localparam int unsigned IdxW = (LIST_LEN > 1) ? $clog2(LIST_LEN) : 1;

  logic                                   busy_q, busy_d;
  logic [LIST_LEN-1:0][sfr_pkg::ByteW-1:0] bytes_q;
  logic [CountW-1:0]                      count_q;
  logic                                   last_q;
  logic [IdxW-1:0]                        idx_q, idx_d;
  logic                                   final_beat, done, load;

  assign final_beat = (count_q == '0) || ((CountW'(idx_q) + 1'b1) == count_q);
  assign done       = busy_q && pop && final_beat;
  assign load       = !q_empty_i && (!busy_q || done);
  assign q_pop_o    = load;

  assign empty            = !busy_q;
  assign out_byte_valid_o = (count_q != '0);
  assign out_byte_o       = out_byte_valid_o ? bytes_q[idx_q] : '0;
  assign out_last_o       = last_q && final_beat;

  always_comb begin
    busy_d = busy_q;
    idx_d  = idx_q;
    if (load) begin
      busy_d = 1'b1;
      idx_d  = '0;
    end else if (done) begin
      busy_d = 1'b0;
    end else if (busy_q && pop) begin
      idx_d = idx_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
    end else begin
      busy_q <= busy_d;
      idx_q  <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      bytes_q <= q_bytes_i;
      count_q <= q_count_i;
      last_q  <= q_last_i;
    end
  end

endmodule

// File: src/stream_find_and_replace_top.sv
// top level: config registers, front end, command queue and back end
// Streaming find-and-replace. Push one text byte per beat with push/full;
// edited beats come out with empty/pop. Every leftmost, non-overlapping
// occurrence of the pattern is replaced; in_last flushes the held bytes and
// the final beat carries out_last (a bare end mark has out_byte_valid low).
// An input beat is taken every cycle while the two-entry command queue has
// room; each input beat becomes at most one command, and the back end sends
// one output beat per cycle while pop is held, so a match with an R-byte
// replacement or a final flush of k bytes holds the output for R or k beats
// and input stalls once the queue fills behind it. A command enters the
// queue at the edge that accepts its input beat, then loads the back-end
// registers, which drive the output. Write configuration only when idle.
module stream_find_and_replace_top #(
  parameter int unsigned MAX_PATTERN     = sfr_pkg::MaxPattern,
  parameter int unsigned MAX_REPLACEMENT = sfr_pkg::MaxReplacement
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push,
  output logic                          full,
  input  logic [sfr_pkg::ByteW-1:0]     in_byte_i,
  input  logic                          in_last_i,
  output logic                          empty,
  input  logic                          pop,
  output logic [sfr_pkg::ByteW-1:0]     out_byte_o,
  output logic                          out_byte_valid_o,
  output logic                          out_last_o,
  input  logic                          cfg_we_i,
  input  logic [sfr_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [sfr_pkg::CfgDataW-1:0]  cfg_data_i
);

  localparam int unsigned ListLen = (MAX_PATTERN > MAX_REPLACEMENT) ?
                                    MAX_PATTERN : MAX_REPLACEMENT;
  localparam int unsigned CountW  = $clog2(ListLen + 1);
  localparam int unsigned BytesW  = ListLen * sfr_pkg::ByteW;
  localparam int unsigned CmdW    = BytesW + CountW + 1;

  logic [sfr_pkg::CfgDataW-1:0] pattern_bytes_q, replacement_bytes_q;
  logic [sfr_pkg::LenW-1:0]     pattern_length_q, replacement_length_q;

  logic                                      accept;
  logic                                      cmd_push;
  logic [ListLen-1:0][sfr_pkg::ByteW-1:0]    cmd_bytes, q_bytes;
  logic [CountW-1:0]                         cmd_count, q_count;
  logic                                      cmd_last, q_last;
  logic [CmdW-1:0]                           q_wdata, q_rdata;
  logic                                      q_pop, q_empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pattern_bytes_q      <= '0;
      pattern_length_q     <= sfr_pkg::LenW'(1);
      replacement_bytes_q  <= '0;
      replacement_length_q <= '0;
    end else if (cfg_we_i) begin
      unique case (sfr_pkg::cfg_reg_e'(cfg_idx_i))
        sfr_pkg::CfgPatternBytes: pattern_bytes_q      <= cfg_data_i;
        sfr_pkg::CfgPatternLen:   pattern_length_q     <= cfg_data_i[sfr_pkg::LenW-1:0];
        sfr_pkg::CfgReplBytes:    replacement_bytes_q  <= cfg_data_i;
        sfr_pkg::CfgReplLen:      replacement_length_q <= cfg_data_i[sfr_pkg::LenW-1:0];
        default: ;
      endcase
    end
  end

  assign accept = push && !full;

  sfr_front #(
    .MAX_PATTERN     (MAX_PATTERN),
    .MAX_REPLACEMENT (MAX_REPLACEMENT)
  ) u_front (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .accept_i             (accept),
    .in_byte_i            (in_byte_i),
    .in_last_i            (in_last_i),
    .pattern_bytes_i      (pattern_bytes_q),
    .pattern_length_i     (pattern_length_q),
    .replacement_bytes_i  (replacement_bytes_q),
    .replacement_length_i (replacement_length_q),
    .cmd_push_o           (cmd_push),
    .cmd_bytes_o          (cmd_bytes),
    .cmd_count_o          (cmd_count),
    .cmd_last_o           (cmd_last)
  );

  assign q_wdata = {cmd_last, cmd_count, cmd_bytes};
  assign q_bytes = q_rdata[BytesW-1:0];
  assign q_count = q_rdata[BytesW +: CountW];
  assign q_last  = q_rdata[CmdW-1];

  sfr_queue #(
    .WIDTH (CmdW),
    .DEPTH (sfr_pkg::QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .data_i  (q_wdata),
    .pop_i   (q_pop),
    .data_o  (q_rdata),
    .full_o  (full),
    .empty_o (q_empty)
  );

  sfr_back #(
    .LIST_LEN (ListLen)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .q_empty_i        (q_empty),
    .q_bytes_i        (q_bytes),
    .q_count_i        (q_count),
    .q_last_i         (q_last),
    .q_pop_o          (q_pop),
    .pop              (pop),
    .empty            (empty),
    .out_byte_o       (out_byte_o),
    .out_byte_valid_o (out_byte_valid_o),
    .out_last_o       (out_last_o)
  );

endmodule
